// ===== sv/spmf_pkg.sv =====
package spmf_pkg;

  localparam int NUM_LEVELS_DEF    = 8;
  localparam int POOL_DEPTH_DEF    = 64;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  localparam int PRIO_IN_W  = 8;
  localparam int PRIO_OUT_W = 3;
  localparam int STATUS_W   = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_POP  = 2'd2
  } cell_op_t;

endpackage

// ===== sv/spmf_req_if.sv =====
interface spmf_req_if #(
  parameter int PAYLOAD_WIDTH = spmf_pkg::PAYLOAD_WIDTH_DEF
) ();
  import spmf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [PRIO_IN_W-1:0]     priority_req;
  logic [PAYLOAD_WIDTH-1:0] payload;

  modport source (output valid, output req_type, output priority_req, output payload,
                  input ready);
  modport sink   (input valid, input req_type, input priority_req, input payload,
                  output ready);
endinterface

// ===== sv/spmf_rsp_if.sv =====
interface spmf_rsp_if #(
  parameter int PAYLOAD_WIDTH = spmf_pkg::PAYLOAD_WIDTH_DEF
) ();
  import spmf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [PAYLOAD_WIDTH-1:0] out_payload;
  logic [PRIO_OUT_W-1:0]    out_priority;

  modport source (output valid, output status, output out_payload, output out_priority,
                  input ready);
  modport sink   (input valid, input status, input out_payload, input out_priority,
                  output ready);
endinterface

// ===== sv/spmf_level_cell.sv =====
module spmf_level_cell #(
  parameter int LVL_W   = 3,
  parameter int PTR_W   = 6,
  parameter int LVL_IDX = 0,
  parameter type cmd_t  = logic,
  parameter type find_t = logic
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  find_t            find_in,
  output find_t            find_out,
  output logic             nonempty,
  output logic [PTR_W-1:0] tail
);
  import spmf_pkg::*;

  logic             ne_r, ne_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic             hit;

  assign hit      = (cmd.lvl == LVL_W'(LVL_IDX));
  assign nonempty = ne_r;
  assign tail     = tail_r;

  // The first non-empty level seen along the row claims the pop.
  always_comb begin
    find_out = find_in;
    if (!find_in.found && ne_r) begin
      find_out.found = 1'b1;
      find_out.lvl   = LVL_W'(LVL_IDX);
      find_out.head  = head_r;
      find_out.tail  = tail_r;
    end
  end

  always_comb begin
    ne_nxt   = ne_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    case (cmd.op)
      OP_INS: begin
        if (hit) begin
          if (!ne_r) begin
            head_nxt = cmd.entry;
          end
          tail_nxt = cmd.entry;
          ne_nxt   = 1'b1;
        end
      end
      OP_POP: begin
        if (hit) begin
          if (cmd.last) begin
            ne_nxt = 1'b0;
          end else begin
            head_nxt = cmd.link;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r <= 1'b0;
    end else begin
      ne_r <= ne_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule

// ===== sv/spmf_pool.sv =====
module spmf_pool #(
  parameter int POOL_DEPTH    = 64,
  parameter int PTR_W         = 6,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [PTR_W-1:0]         rd_addr,
  output logic [PAYLOAD_WIDTH-1:0] rd_payload,
  output logic [PTR_W-1:0]         rd_next,
  input  logic                     pay_we,
  input  logic [PTR_W-1:0]         pay_waddr,
  input  logic [PAYLOAD_WIDTH-1:0] pay_wdata,
  input  logic                     nxt_we,
  input  logic [PTR_W-1:0]         nxt_waddr,
  input  logic [PTR_W-1:0]         nxt_wdata
);

  logic [PAYLOAD_WIDTH-1:0] pay_mem [POOL_DEPTH];
  logic [PTR_W-1:0]         nxt_mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_waddr] <= pay_wdata;
    end
    if (rd_en) begin
      rd_payload <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_waddr] <= nxt_wdata;
    end
    if (rd_en) begin
      rd_next <= nxt_mem[rd_addr];
    end
  end

endmodule

// ===== sv/strict_priority_multi_fifo.sv =====
// Strict-priority message queue: NUM_LEVELS FIFOs (level 0 best) share a linked pool of
// POOL_DEPTH entries. An insert item is appended at its clamped level, or reported as
// dropped when the pool is full; a pop item returns the head of the best non-empty level,
// or reports empty. Every item yields one result item. Each item goes through S_IDLE, where the
// accept looks up the level row and reads the pool memory, whose read is registered, and
// then S_EXEC, which applies the update and loads the output register; a stalled output
// holds S_EXEC. One item is in work at a time. The pool needs no clearing pass after
// reset: entries never handed out are tracked by a fill count, so the block accepts
// items as soon as reset is released.
module strict_priority_multi_fifo #(
  parameter int NUM_LEVELS    = spmf_pkg::NUM_LEVELS_DEF,
  parameter int POOL_DEPTH    = spmf_pkg::POOL_DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = spmf_pkg::PAYLOAD_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  spmf_req_if.sink   in_ch,
  spmf_rsp_if.source out_ch
);
  import spmf_pkg::*;

  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int PTR_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);

  typedef struct packed {
    cell_op_t         op;
    logic [LVL_W-1:0] lvl;
    logic [PTR_W-1:0] entry;
    logic [PTR_W-1:0] link;
    logic             last;
  } cell_cmd_t;

  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] lvl;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
  } level_find_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic [PTR_W-1:0]         free_head_r, free_head_nxt;
  logic [CNT_W-1:0]         used_r, used_nxt;
  logic [CNT_W-1:0]         fresh_r, fresh_nxt;

  logic                     is_pop_r;
  logic                     found_r;
  logic                     full_r;
  logic                     last_r;
  logic [LVL_W-1:0]         lvl_r;
  logic [PTR_W-1:0]         e_r;
  logic [PAYLOAD_WIDTH-1:0] pay_r;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [PAYLOAD_WIDTH-1:0] out_payload_r;
  logic [PRIO_OUT_W-1:0]    out_priority_r;

  level_find_t              find_chain [NUM_LEVELS+1];
  logic [NUM_LEVELS-1:0]    level_ne;
  logic [PTR_W-1:0]         level_tail [NUM_LEVELS];
  cell_cmd_t                cmd;

  logic                     accept;
  logic                     finish;
  logic                     ins_ok;
  logic                     pop_ok;
  logic                     fresh_hit;
  logic [PTR_W-1:0]         fresh_link;
  logic [LVL_W-1:0]         in_lvl;

  logic                     rd_en;
  logic [PTR_W-1:0]         rd_addr;
  logic [PAYLOAD_WIDTH-1:0] rd_payload;
  logic [PTR_W-1:0]         rd_next;
  logic                     pay_we;
  logic                     nxt_we;
  logic [PTR_W-1:0]         nxt_waddr;
  logic [PTR_W-1:0]         nxt_wdata;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign finish      = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign ins_ok      = !is_pop_r && !full_r;
  assign pop_ok      = is_pop_r && found_r;

  assign in_lvl = (in_ch.priority_req > PRIO_IN_W'(NUM_LEVELS - 1)) ?
                  LVL_W'(NUM_LEVELS - 1) : in_ch.priority_req[LVL_W-1:0];

  // An entry at the fill count has never been handed out, so its link is the next index.
  assign fresh_hit  = (CNT_W'(e_r) == fresh_r);
  assign fresh_link = (e_r == PTR_W'(POOL_DEPTH - 1)) ? '0 : e_r + 1'b1;

  assign find_chain[0] = '0;

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    spmf_level_cell #(
      .LVL_W   (LVL_W),
      .PTR_W   (PTR_W),
      .LVL_IDX (g),
      .cmd_t   (cell_cmd_t),
      .find_t  (level_find_t)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .find_in  (find_chain[g]),
      .find_out (find_chain[g+1]),
      .nonempty (level_ne[g]),
      .tail     (level_tail[g])
    );
  end

  assign rd_en   = accept;
  assign rd_addr = (in_ch.req_type == REQ_POP) ? find_chain[NUM_LEVELS].head : free_head_r;

  assign pay_we    = finish && ins_ok;
  assign nxt_we    = finish && ((ins_ok && level_ne[lvl_r]) || pop_ok);
  assign nxt_waddr = is_pop_r ? e_r : level_tail[lvl_r];
  assign nxt_wdata = is_pop_r ? free_head_r : e_r;

  spmf_pool #(
    .POOL_DEPTH    (POOL_DEPTH),
    .PTR_W         (PTR_W),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_pool (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_payload (rd_payload),
    .rd_next    (rd_next),
    .pay_we     (pay_we),
    .pay_waddr  (e_r),
    .pay_wdata  (pay_r),
    .nxt_we     (nxt_we),
    .nxt_waddr  (nxt_waddr),
    .nxt_wdata  (nxt_wdata)
  );

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.lvl   = lvl_r;
    cmd.entry = e_r;
    cmd.link  = rd_next;
    cmd.last  = last_r;
    if (finish && ins_ok) begin
      cmd.op = OP_INS;
    end else if (finish && pop_ok) begin
      cmd.op = OP_POP;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    free_head_nxt = free_head_r;
    used_nxt      = used_r;
    fresh_nxt     = fresh_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          state_nxt = S_IDLE;
          if (ins_ok) begin
            free_head_nxt = fresh_hit ? fresh_link : rd_next;
            used_nxt      = used_r + 1'b1;
            if (fresh_hit) begin
              fresh_nxt = fresh_r + 1'b1;
            end
          end else if (pop_ok) begin
            free_head_nxt = e_r;
            used_nxt      = used_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      used_r      <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      used_r      <= used_nxt;
      fresh_r     <= fresh_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_pop_r <= (in_ch.req_type == REQ_POP);
      pay_r    <= in_ch.payload;
      full_r   <= (used_r == CNT_W'(POOL_DEPTH));
      found_r  <= find_chain[NUM_LEVELS].found;
      last_r   <= (find_chain[NUM_LEVELS].head == find_chain[NUM_LEVELS].tail);
      if (in_ch.req_type == REQ_POP) begin
        lvl_r <= find_chain[NUM_LEVELS].found ? find_chain[NUM_LEVELS].lvl : '0;
        e_r   <= find_chain[NUM_LEVELS].head;
      end else begin
        lvl_r <= in_lvl;
        e_r   <= free_head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_priority_r <= PRIO_OUT_W'(lvl_r);
      out_payload_r  <= pop_ok ? rd_payload : '0;
      if (is_pop_r) begin
        out_status_r <= found_r ? ST_POPPED : ST_EMPTY;
      end else begin
        out_status_r <= full_r ? ST_DROPPED : ST_INSERTED;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_payload  = out_payload_r;
  assign out_ch.out_priority = out_priority_r;

  a_used_le_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r <= fresh_r) && (fresh_r <= CNT_W'(POOL_DEPTH)))
    else $error("used count exceeds the handed-out count");

  a_empty_levels_no_used: assert property (@(posedge clk) disable iff (!rst_n)
    (level_ne == '0) |-> (used_r == '0))
    else $error("entries in use while every level is empty");

  a_empty_pop_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && is_pop_r && !found_r) |-> (level_ne == '0))
    else $error("pop reported empty with a non-empty level");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result item appeared without an executed item");

endmodule
